// ===== src/svc_pkg.sv =====
// package: state type, register indexes and constants of the slip valve controller
package svc_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_EVAL
   } fsm_state_type;

   typedef enum logic [2:0] {
      CSR_RATIO_LEFT  = 3'd0,
      CSR_RATIO_RIGHT = 3'd1,
      CSR_RATIO_DIFF  = 3'd2,
      CSR_SLIP_ON     = 3'd3,
      CSR_SLIP_OFF    = 3'd4,
      CSR_SPEED_LIMIT = 3'd5,
      CSR_RELEASE_MS  = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CH_LEFT  = 2'd0,
      CH_RIGHT = 2'd1,
      CH_DIFF  = 2'd2,
      CH_SLIP  = 2'd3
   } div_channel_type;

   localparam logic [15:0] RATIO_RESET       = 16'd256;
   localparam logic [15:0] SLIP_ON_RESET     = 16'd819;
   localparam logic [15:0] SLIP_OFF_RESET    = 16'd410;
   localparam logic [15:0] SPEED_LIMIT_RESET = 16'd12800;
   localparam logic [15:0] RELEASE_MS_RESET  = 16'd1000;

   localparam logic [16:0] SLIP_ONE     = 17'd4096;
   localparam logic [15:0] SLIP_MAX     = 16'h7FFF;
   localparam logic [15:0] SLIP_SAT_Q   = 16'd36864;
   localparam logic [15:0] SPEED_MAX    = 16'hFFFF;
   localparam logic [3:0]  DIV_LAST     = 4'd15;

endpackage

// ===== src/slip_valve_controller_core.sv =====
// top level: wheel-slip valve controller with a shared bit-serial divider
//
//  port group  direction  handshake            payload
//  req_*       in         req_valid/req_ready  freq_left, freq_right, freq_diff, now_ms
//  rsp_*       out        rsp_valid/rsp_ready  valve_on, slip_ratio, vehicle_speed
//  csr_*       in         csr_we               csr_index, csr_wdata
//
// one transaction runs four divisions one after the other on one restoring divider that
// makes one quotient bit per cycle (a load state, then the division state, for each);
// a zero frequency, an overflowing quotient or a zero vehicle speed skips its division.
// reset clears the control and valve state and sets the registers to their reset values.
// a waiting response holds the block in its last cycle only; req_ready is high in idle.
module slip_valve_controller_core
   import svc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_freq_left,
   input  logic [15:0] req_freq_right,
   input  logic [15:0] req_freq_diff,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valve_on,
   output logic signed [15:0] rsp_slip_ratio,
   output logic [15:0] rsp_vehicle_speed,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   fsm_state_type   state_ff, state_in;
   div_channel_type ch_ff, ch_in;
   logic [3:0]      cnt_ff, cnt_in;

   logic [15:0] ratio_l_ff, ratio_r_ff, ratio_d_ff;
   logic signed [15:0] slip_on_ff, slip_off_ff;
   logic [15:0] speed_limit_ff, release_ms_ff;

   logic [15:0] freq_l_ff, freq_r_ff, freq_d_ff;
   logic [31:0] now_ff;
   logic [15:0] sl_ff, sl_in, sr_ff, sr_in, sd_ff, sd_in;

   logic [15:0] rem_ff, rem_in, dq_ff, dq_in, dvs_ff, dvs_in;
   logic [15:0] slip_ff, slip_in;
   logic        slip_ok_ff, slip_ok_in;

   logic        valve_ff, valve_in, request_ff, request_in;
   logic [31:0] start_ff, start_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_valve_ff;
   logic [15:0] rsp_slip_ff, rsp_speed_ff;

   // control decoded from state
   logic        accept, push, ld_special, div_done, finish;
   logic [15:0] ld_freq, ld_ratio, ld_value, fin_value;
   logic [16:0] avg_sum;
   logic [15:0] avg;
   logic        diff_big;
   logic [16:0] rem_shift;
   logic        step_ge;
   logic [16:0] rem_sub;
   logic [16:0] slip_wide;
   logic        set_req, clr_req, act_mid;
   logic [31:0] start_mid, elapsed;

   assign avg_sum  = {1'b0, sl_ff} + {1'b0, sr_ff};
   assign avg      = avg_sum[16:1];
   assign diff_big = {4'b0000, sd_ff} >= {avg, 4'b0000};

   // one restoring step
   assign rem_shift = {rem_ff, dq_ff[15]};
   assign step_ge   = rem_shift >= {1'b0, dvs_ff};
   assign rem_sub   = rem_shift - {1'b0, dvs_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOAD;
         ST_LOAD: begin
            if (ld_special) state_in = (ch_ff == CH_SLIP) ? ST_EVAL : ST_LOAD;
            else state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = (ch_ff == CH_SLIP) ? ST_EVAL : ST_LOAD;
         end
         ST_EVAL: if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      accept     = 1'b0;
      push       = 1'b0;
      div_done   = 1'b0;
      ld_freq    = freq_l_ff;
      ld_ratio   = ratio_l_ff;
      ld_special = 1'b0;
      ld_value   = '0;
      unique case (ch_ff)
         CH_LEFT:  begin ld_freq = freq_l_ff; ld_ratio = ratio_l_ff; end
         CH_RIGHT: begin ld_freq = freq_r_ff; ld_ratio = ratio_r_ff; end
         CH_DIFF:  begin ld_freq = freq_d_ff; ld_ratio = ratio_d_ff; end
         CH_SLIP:  begin ld_freq = freq_d_ff; ld_ratio = avg; end
         default:  begin ld_freq = freq_l_ff; ld_ratio = ratio_l_ff; end
      endcase
      unique case (state_ff)
         ST_IDLE: accept = req_valid;
         ST_LOAD: begin
            if (ch_ff == CH_SLIP) begin
               // zero speed is resolved straight in the slip registers
               ld_special = (avg == '0) || diff_big;
               ld_value   = SPEED_MAX;
            end else if (ld_freq == '0) begin
               ld_special = 1'b1;
               ld_value   = '0;
            end else if (ld_freq >= ld_ratio) begin
               ld_special = 1'b1;
               ld_value   = SPEED_MAX;
            end
         end
         ST_DIV:  div_done = (cnt_ff == DIV_LAST);
         ST_EVAL: push = !rsp_valid_ff || rsp_ready;
         default: accept = 1'b0;
      endcase
   end

   assign finish    = (state_ff == ST_LOAD && ld_special) || div_done;
   assign fin_value = div_done ? {dq_ff[14:0], step_ge} : ld_value;
   assign slip_wide = {1'b0, fin_value} - SLIP_ONE;

   // datapath next values
   always_comb begin
      ch_in      = ch_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      dvs_in     = dvs_ff;
      sl_in      = sl_ff;
      sr_in      = sr_ff;
      sd_in      = sd_ff;
      slip_in    = slip_ff;
      slip_ok_in = slip_ok_ff;
      if (accept) ch_in = CH_LEFT;
      if (state_ff == ST_LOAD && !ld_special) begin
         cnt_in = '0;
         dvs_in = ld_ratio;
         if (ch_ff == CH_SLIP) begin
            // dividend is diff speed times 4096, top 12 bits preload the remainder
            rem_in = {4'b0000, sd_ff[15:4]};
            dq_in  = {sd_ff[3:0], 12'h000};
         end else begin
            rem_in = ld_freq;
            dq_in  = '0;
         end
      end
      if (state_ff == ST_DIV) begin
         cnt_in = cnt_ff + 4'd1;
         rem_in = step_ge ? rem_sub[15:0] : rem_shift[15:0];
         dq_in  = {dq_ff[14:0], step_ge};
      end
      if (finish) begin
         if (ch_ff != CH_SLIP) ch_in = div_channel_type'(ch_ff + 2'd1);
         unique case (ch_ff)
            CH_LEFT:  sl_in = fin_value;
            CH_RIGHT: sr_in = fin_value;
            CH_DIFF:  sd_in = fin_value;
            CH_SLIP: begin
               if (avg == '0) begin
                  slip_ok_in = (freq_d_ff != '0);
                  slip_in    = (freq_d_ff != '0) ? SLIP_MAX : '0;
               end else begin
                  slip_ok_in = 1'b1;
                  slip_in    = (fin_value >= SLIP_SAT_Q) ? SLIP_MAX : slip_wide[15:0];
               end
            end
            default:  sl_in = fin_value;
         endcase
      end
   end

   // request hysteresis and valve timer
   always_comb begin
      set_req = ($signed(slip_ff) > slip_on_ff) && (avg < speed_limit_ff);
      clr_req = $signed(slip_ff) < slip_off_ff;
      request_in = request_ff;
      if (slip_ok_ff) begin
         if (set_req) request_in = 1'b1;
         else if (clr_req) request_in = 1'b0;
      end
      act_mid   = valve_ff || request_in;
      start_mid = (!valve_ff && request_in) ? now_ff : start_ff;
      elapsed   = now_ff - start_mid;
      valve_in  = act_mid && !(elapsed > {16'h0000, release_ms_ff});
      start_in  = start_mid;
      rsp_valid_in = push ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         ch_ff          <= CH_LEFT;
         cnt_ff         <= '0;
         ratio_l_ff     <= RATIO_RESET;
         ratio_r_ff     <= RATIO_RESET;
         ratio_d_ff     <= RATIO_RESET;
         slip_on_ff     <= SLIP_ON_RESET;
         slip_off_ff    <= SLIP_OFF_RESET;
         speed_limit_ff <= SPEED_LIMIT_RESET;
         release_ms_ff  <= RELEASE_MS_RESET;
         valve_ff       <= 1'b0;
         request_ff     <= 1'b0;
         start_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (push) begin
            valve_ff   <= valve_in;
            request_ff <= request_in;
            start_ff   <= start_in;
         end
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_RATIO_LEFT:  ratio_l_ff     <= csr_wdata;
               CSR_RATIO_RIGHT: ratio_r_ff     <= csr_wdata;
               CSR_RATIO_DIFF:  ratio_d_ff     <= csr_wdata;
               CSR_SLIP_ON:     slip_on_ff     <= csr_wdata;
               CSR_SLIP_OFF:    slip_off_ff    <= csr_wdata;
               CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata;
               CSR_RELEASE_MS:  release_ms_ff  <= csr_wdata;
               CSR_UNUSED:      ;
               default:         ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         freq_l_ff <= req_freq_left;
         freq_r_ff <= req_freq_right;
         freq_d_ff <= req_freq_diff;
         now_ff    <= req_now_ms;
      end
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      dvs_ff     <= dvs_in;
      sl_ff      <= sl_in;
      sr_ff      <= sr_in;
      sd_ff      <= sd_in;
      slip_ff    <= slip_in;
      slip_ok_ff <= slip_ok_in;
      if (push) begin
         rsp_valve_ff <= valve_in;
         rsp_slip_ff  <= slip_ff;
         rsp_speed_ff <= avg;
      end
   end

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valve_on      = rsp_valve_ff;
   assign rsp_slip_ratio    = rsp_slip_ff;
   assign rsp_vehicle_speed = rsp_speed_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for slip_valve_controller_core: directed and random control calls checked by a scoreboard
module tb_top
   import svc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // mirror of the controller: registers, valve state and the results still owed
   class slip_scoreboard;
      typedef struct {
         logic        valve;
         logic [15:0] slip;
         logic [15:0] speed;
      } valve_result_type;

      logic [15:0]      ratio_left;
      logic [15:0]      ratio_right;
      logic [15:0]      ratio_diff;
      shortint          slip_on;
      shortint          slip_off;
      logic [15:0]      speed_limit;
      logic [15:0]      release_ms;
      logic             valve_active;
      logic             slip_request;
      logic [31:0]      valve_start;
      valve_result_type owed_results[$];
      int               failures;

      function new();
         ratio_left   = RATIO_RESET;
         ratio_right  = RATIO_RESET;
         ratio_diff   = RATIO_RESET;
         slip_on      = shortint'(SLIP_ON_RESET);
         slip_off     = shortint'(SLIP_OFF_RESET);
         speed_limit  = SPEED_LIMIT_RESET;
         release_ms   = RELEASE_MS_RESET;
         valve_active = 1'b0;
         slip_request = 1'b0;
         valve_start  = 32'd0;
         failures     = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [15:0] val);
         case (idx)
            CSR_RATIO_LEFT:  ratio_left  = val;
            CSR_RATIO_RIGHT: ratio_right = val;
            CSR_RATIO_DIFF:  ratio_diff  = val;
            CSR_SLIP_ON:     slip_on     = shortint'(val);
            CSR_SLIP_OFF:    slip_off    = shortint'(val);
            CSR_SPEED_LIMIT: speed_limit = val;
            CSR_RELEASE_MS:  release_ms  = val;
            default: ;
         endcase
      endfunction

      function logic [15:0] wheel_speed(logic [15:0] freq, logic [15:0] ratio);
         logic [31:0] q;
         if (ratio == 16'd0) return (freq != 16'd0) ? SPEED_MAX : 16'd0;
         q = {freq, 16'h0000} / {16'h0000, ratio};
         return (q > 32'h0000_FFFF) ? SPEED_MAX : q[15:0];
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction

      function void note_request(logic [15:0] fl, logic [15:0] fr, logic [15:0] fd,
                                 logic [31:0] now);
         logic [15:0]      sl;
         logic [15:0]      sr;
         logic [15:0]      sd;
         logic [16:0]      sum;
         logic [15:0]      avg;
         logic [27:0]      num;
         logic [31:0]      elapsed;
         int               slip;
         bit               slip_known;
         valve_result_type outcome;
         sl  = wheel_speed(fl, ratio_left);
         sr  = wheel_speed(fr, ratio_right);
         sd  = wheel_speed(fd, ratio_diff);
         sum = {1'b0, sl} + {1'b0, sr};
         avg = sum[16:1];
         slip = 0;
         slip_known = 1'b1;
         if (avg == 16'd0) begin
            // standing still: saturate if the differential still turns, else hold
            if (fd != 16'd0) slip = int'(SLIP_MAX);
            else slip_known = 1'b0;
         end else begin
            num  = {sd, 12'h000};
            slip = int'(num / {12'h000, avg}) - int'(SLIP_ONE);
            if (slip > int'(SLIP_MAX)) slip = int'(SLIP_MAX);
            if (slip < -32768) slip = -32768;
         end
         if (slip_known) begin
            if (slip > int'(slip_on) && avg < speed_limit) slip_request = 1'b1;
            else if (slip < int'(slip_off)) slip_request = 1'b0;
         end
         if (!valve_active && slip_request) begin
            valve_active = 1'b1;
            valve_start  = now;
         end
         elapsed = now - valve_start;
         if (valve_active && elapsed > {16'h0000, release_ms}) valve_active = 1'b0;
         outcome.valve = valve_active;
         outcome.slip  = slip[15:0];
         outcome.speed = avg;
         owed_results.push_back(outcome);
      endfunction

      function void check_response(logic valve, logic [15:0] slip, logic [15:0] speed);
         valve_result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: response with nothing owed: valve_on %0b slip_ratio %0d speed %0d",
                     $time, valve, $signed(slip), speed);
            failures++;
            return;
         end
         want = owed_results.pop_front();
         if (want.valve !== valve) begin
            $display("%0t: valve_on expected %0b actual %0b", $time, want.valve, valve);
            failures++;
         end
         if (want.slip !== slip) begin
            $display("%0t: slip_ratio expected %0d actual %0d", $time,
                     $signed(want.slip), $signed(slip));
            failures++;
         end
         if (want.speed !== speed) begin
            $display("%0t: vehicle_speed expected %0d actual %0d", $time, want.speed, speed);
            failures++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [15:0] req_freq_left;
   logic [15:0] req_freq_right;
   logic [15:0] req_freq_diff;
   logic [31:0] req_now_ms;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_valve_on;
   logic signed [15:0] rsp_slip_ratio;
   logic [15:0] rsp_vehicle_speed;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   slip_scoreboard sb;
   int          sender_idle = 0;
   int          rsp_stall = 0;
   logic [31:0] ms_now;

   slip_valve_controller_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_freq_left     (req_freq_left),
      .req_freq_right    (req_freq_right),
      .req_freq_diff     (req_freq_diff),
      .req_now_ms        (req_now_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_valve_on      (rsp_valve_on),
      .rsp_slip_ratio    (rsp_slip_ratio),
      .rsp_vehicle_speed (rsp_vehicle_speed),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      rsp_ready = ($urandom_range(0, 99) >= rsp_stall);
   end

   // response is checked before the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_valve_on, rsp_slip_ratio, rsp_vehicle_speed);
         if (req_valid && req_ready)
            sb.note_request(req_freq_left, req_freq_right, req_freq_diff, req_now_ms);
         if (csr_we)
            sb.set_register(csr_index_type'(csr_index), csr_wdata);
      end
   end

   task automatic send_item(input logic [15:0] fl, input logic [15:0] fr,
                            input logic [15:0] fd, input logic [31:0] now);
      @(negedge clock);
      if ($urandom_range(0, 99) < sender_idle) begin
         req_valid = 1'b0;
         do @(negedge clock); while ($urandom_range(0, 99) < sender_idle);
      end
      req_valid      = 1'b1;
      req_freq_left  = fl;
      req_freq_right = fr;
      req_freq_diff  = fd;
      req_now_ms     = now;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
   endtask

   task automatic program_registers(input logic [15:0] rl, input logic [15:0] rr,
                                    input logic [15:0] rd, input logic [15:0] on,
                                    input logic [15:0] off, input logic [15:0] lim,
                                    input logic [15:0] rel);
      wait_drained();
      write_csr(CSR_RATIO_LEFT, rl);
      write_csr(CSR_RATIO_RIGHT, rr);
      write_csr(CSR_RATIO_DIFF, rd);
      write_csr(CSR_SLIP_ON, on);
      write_csr(CSR_SLIP_OFF, off);
      write_csr(CSR_SPEED_LIMIT, lim);
      write_csr(CSR_RELEASE_MS, rel);
      // the spare index must not land in any register
      write_csr(CSR_UNUSED, 16'($urandom));
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin sender_idle = 0;  rsp_stall = 0;  end
         1: begin sender_idle = 85; rsp_stall = 0;  end
         2: begin sender_idle = 0;  rsp_stall = 85; end
         default: begin sender_idle = 28; rsp_stall = 28; end
      endcase
   endtask

   task automatic choose_settings(input int variant);
      logic [15:0] rl;
      logic [15:0] rr;
      logic [15:0] rd;
      logic [15:0] lim;
      logic [15:0] rel;
      int          on;
      int          off;
      int          which;
      rl  = 16'($urandom_range(64, 1024));
      rr  = 16'($urandom_range(64, 1024));
      rd  = 16'($urandom_range(64, 1024));
      on  = int'($urandom_range(0, 3000)) - 500;
      off = on - int'($urandom_range(0, 800));
      lim = 16'($urandom_range(2000, 40000));
      rel = 16'($urandom_range(0, 40));
      case (variant)
         1: begin
            rl = 16'd1; rr = 16'd1; rd = 16'd1;
            lim = 16'hFFFF; rel = 16'd0;
         end
         2: begin
            rl = 16'hFFFF; rr = 16'hFFFF; rd = 16'hFFFF;
            on = -32768; off = -32768;
            lim = 16'hFFFF; rel = 16'hFFFF;
         end
         3: begin
            which = $urandom_range(0, 2);
            if (which == 0) rl = 16'd0;
            else if (which == 1) rr = 16'd0;
            else rd = 16'd0;
            lim = $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
         end
         default: ;
      endcase
      program_registers(rl, rr, rd, 16'(on), 16'(off), lim, rel);
   endtask

   // frequency that gives roughly the wanted speed at a channel's pulse ratio
   function automatic logic [15:0] freq_for_speed(input int speed, input logic [15:0] ratio);
      longint f;
      if (ratio == 16'd0) return ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
      f = (longint'(speed) * longint'(ratio)) >>> 16;
      if (f > 65535) return 16'hFFFF;
      return 16'(f);
   endfunction

   task automatic random_item();
      logic [15:0] fl;
      logic [15:0] fr;
      logic [15:0] fd;
      int          s;
      int          k;
      int          ds;
      if ($urandom_range(0, 99) < 15) begin
         fl = 16'($urandom);
         fr = 16'($urandom);
         fd = 16'($urandom);
         if ($urandom_range(0, 1)) ms_now = $urandom;
         else ms_now = ms_now + $urandom_range(0, 100000);
      end else begin
         // coherent wheel speeds with a slip spread around the usual thresholds
         if ($urandom_range(0, 3) == 0) s = $urandom_range(0, 65535);
         else s = $urandom_range(0, sb.speed_limit + 256);
         if (s > 65535) s = 65535;
         k  = int'($urandom_range(0, 6144)) - 2048;
         ds = s + (s * k) / 4096;
         if (ds > 65535) ds = 65535;
         if (ds < 0) ds = 0;
         fl = freq_for_speed(s, sb.ratio_left);
         fr = freq_for_speed(s, sb.ratio_right);
         fd = freq_for_speed(ds, sb.ratio_diff);
         if ($urandom_range(0, 9) == 0)
            ms_now = ms_now + $urandom_range(0, 2 * int'(sb.release_ms) + 2);
         else
            ms_now = ms_now + $urandom_range(0, 4);
      end
      send_item(fl, fr, fd, ms_now);
   endtask

   initial begin
      sb = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_freq_left  = 16'd0;
      req_freq_right = 16'd0;
      req_freq_diff  = 16'd0;
      req_now_ms     = 32'd0;
      csr_we         = 1'b0;
      csr_index      = CSR_RATIO_LEFT;
      csr_wdata      = 16'd0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: hold at standstill, release timing, re-arm, saturation, wrap
      set_idle_mode(0);
      send_item(16'd0, 16'd0, 16'd0, 32'd0);
      send_item(16'd0, 16'd0, 16'd1, 32'd10);
      send_item(16'd0, 16'd0, 16'd0, 32'd500);
      send_item(16'd40, 16'd40, 16'd40, 32'd1010);
      send_item(16'd40, 16'd40, 16'd40, 32'd1011);
      send_item(16'd40, 16'd40, 16'd50, 32'd1020);
      send_item(16'd40, 16'd40, 16'd45, 32'd1500);
      send_item(16'd40, 16'd40, 16'd45, 32'd2021);
      send_item(16'd40, 16'd40, 16'd45, 32'd2022);
      send_item(16'd60, 16'd60, 16'd80, 32'd2100);
      send_item(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'd3000);
      send_item(16'd40, 16'd40, 16'd0, 32'd3100);
      send_item(16'd1, 16'd0, 16'd255, 32'd3200);
      send_item(16'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
      send_item(16'd0, 16'd0, 16'd0, 32'h0000_0100);

      // zero and extreme ratios, widest thresholds, no release delay
      program_registers(16'd0, 16'd1, 16'hFFFF, 16'h8000, 16'h7FFF, 16'hFFFF, 16'd0);
      send_item(16'd0, 16'd5, 16'd0, 32'd0);
      send_item(16'd7, 16'd0, 16'hFFFF, 32'd1);
      send_item(16'd0, 16'd0, 16'd0, 32'd2);
      send_item(16'hFFFF, 16'd0, 16'd0, 32'd3);

      // thresholds that can neither set nor clear, zero speed limit, longest delay
      program_registers(16'd256, 16'd256, 16'd256, 16'h7FFF, 16'h8000, 16'd0, 16'hFFFF);
      send_item(16'd0, 16'd0, 16'd1, 32'd5);
      send_item(16'hFFFF, 16'hFFFF, 16'd0, 32'd70000);
      send_item(16'd1, 16'd0, 16'hFFFF, 32'd70001);

      for (int p = 0; p < 12; p++) begin
         set_idle_mode((p + p / 4) % 4);
         choose_settings(p % 4);
         ms_now = (p == 5) ? 32'hFFFF_FF80 : $urandom;
         for (int i = 0; i < 128; i++) begin
            if ($urandom_range(0, 99) == 0) wait_drained();
            random_item();
         end
      end

      wait_drained();
      repeat (80) @(negedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0)
         $display("slip_valve_controller_core: match");
      else
         $display("slip_valve_controller_core: mismatch");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("slip_valve_controller_core: mismatch");
      $finish;
   end

endmodule
